// ----- hdl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GQD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gqd check failed");

// next-cycle implication, disabled during reset
`define GQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gqd check failed");

`endif

// ----- hdl/gqd_pkg.sv -----
// types and constants of the gray quantizer with dither
`default_nettype none
package gqd_pkg;

  localparam int GRAY_RANGE  = 256;
  localparam int PIX_W       = 8;
  localparam int NOISE_W     = 16;
  localparam int LVL_W       = 9;
  localparam int DIM_W       = 13;
  localparam int NUM_W       = 17;
  localparam int NOISE_DEPTH = 129;
  localparam int NZ_ADDR_W   = 8;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [NZ_ADDR_W-1:0] NOISE_LAST = NZ_ADDR_W'(NOISE_DEPTH - 1);
  localparam logic [16:0]          NOISE_DIV  = 17'd65535;

  localparam logic [LVL_W-1:0] LEVELS_RST = 9'd16;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    REG_LEVELS = 2'd0,
    REG_DITHER = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } gqd_reg_t;

  typedef enum logic [1:0] {
    BLD_IDLE,
    BLD_SETUP,
    BLD_DIV,
    BLD_WRITE
  } gqd_state_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_in;
    logic [NOISE_W-1:0] noise_fraction;
  } gqd_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             plane_end;
  } gqd_out_t;

  typedef struct packed {
    logic             dither_enable;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } gqd_cfg_t;

  typedef struct packed {
    logic                 busy;
    logic                 lvl_we;
    logic                 nz_we;
    logic [PIX_W-1:0]     addr;
    logic [PIX_W-1:0]     lvl_data;
    logic [PIX_W-1:0]     nz_quo;
    logic                 nz_frac;
  } gqd_wr_t;

endpackage
`default_nettype wire

// ----- hdl/gray_quantizer_with_dither.sv -----
// top level of the gray quantizer with dither: register file and datapath
//
//  channel   direction  handshake               payload
//  in_*      input      in_valid / in_ready     gqd_in_t  (pixel_in, noise_fraction)
//  out_*     output     out_valid / out_ready   gqd_out_t (pixel_out, plane_end)
//  apb       input      psel / penable / pready levels, dither_enable, width, height
//
// one pixel per clock while no rebuild runs and the output does not stall; the
// noise table is read into stage one, then the level table into the output register
// after reset and after every write of levels the tables are rebuilt: 256 level
// entries, the first 129 also noise entries, one divider pass each, in_ready low
// a stalled result holds the output register; one more transaction fits behind it
`default_nettype none
module gray_quantizer_with_dither
  import gqd_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gqd_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gqd_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [LVL_W-1:0] levels_r;
  logic             dither_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  gqd_reg_t         reg_idx;
  logic             wr_en;
  logic             build_start;
  gqd_cfg_t         cfg;
  gqd_wr_t          wr;

  assign pready      = 1'b1;
  assign reg_idx     = gqd_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en       = psel && penable && pwrite && pready;
  assign build_start = wr_en && (reg_idx == REG_LEVELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_RST;
      dither_r <= 1'b0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEVELS: levels_r <= pwdata[LVL_W-1:0];
        REG_DITHER: dither_r <= pwdata[0];
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEVELS: prdata = DATA_W'(levels_r);
      REG_DITHER: prdata = DATA_W'(dither_r);
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.dither_enable = dither_r;
  assign cfg.image_width   = width_r;
  assign cfg.image_height  = height_r;

  gqd_build u_build (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (build_start),
    .levels (levels_r),
    .wr     (wr)
  );

  gqd_pipe #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .wr        (wr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- hdl/gqd_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module gqd_div
  import gqd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [LVL_W-1:0] den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [LVL_W-1:0] rem_r, rem_nxt;
  logic [LVL_W-1:0] den_r, den_nxt;
  logic [LVL_W:0]   trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? LVL_W'(trial - {1'b0, den_r}) : trial[LVL_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- hdl/gqd_build.sv -----
// sequencer that rebuilds the level table and the noise table
`default_nettype none
module gqd_build
  import gqd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [LVL_W-1:0] levels,
  output gqd_wr_t               wr
);

  gqd_state_t       state_r, state_nxt;
  logic [PIX_W-1:0] idx_r, idx_nxt;
  logic [PIX_W-1:0] nz_quo_r, nz_quo_nxt;
  logic [LVL_W-1:0] nz_rem_r, nz_rem_nxt;
  logic [LVL_W-1:0] n;
  logic [NUM_W-1:0] prod;
  logic [NUM_W-1:0] num;
  logic [LVL_W:0]   rem_p1;
  logic             div_start;
  logic             div_busy;
  logic [NUM_W-1:0] div_quo;

  assign n    = (levels == '0) ? LVL_W'(1) : levels;
  assign prod = NUM_W'(idx_r) * NUM_W'(n);
  assign num  = {prod[NUM_W-1:PIX_W], 8'h80};

  gqd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (n),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    nz_quo_nxt  = nz_quo_r;
    nz_rem_nxt  = nz_rem_r;
    div_start   = 1'b0;
    rem_p1      = {1'b0, nz_rem_r} + 1'b1;
    wr.busy     = state_r != BLD_IDLE;
    wr.lvl_we   = 1'b0;
    wr.nz_we    = 1'b0;
    wr.addr     = idx_r;
    wr.lvl_data = (div_quo > NUM_W'(GRAY_RANGE - 1)) ? 8'hFF : div_quo[PIX_W-1:0];
    wr.nz_quo   = nz_quo_r;
    wr.nz_frac  = nz_rem_r != '0;
    case (state_r)
      BLD_SETUP: begin
        div_start = 1'b1;
        state_nxt = BLD_DIV;
      end
      BLD_DIV: begin
        if (!div_busy) begin
          state_nxt = BLD_WRITE;
        end
      end
      BLD_WRITE: begin
        wr.lvl_we = 1'b1;
        if (idx_r <= NOISE_LAST) begin
          wr.nz_we = 1'b1;
          if (rem_p1 == {1'b0, n}) begin
            nz_rem_nxt = '0;
            nz_quo_nxt = nz_quo_r + 1'b1;
          end else begin
            nz_rem_nxt = rem_p1[LVL_W-1:0];
          end
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = (idx_r == PIX_W'(GRAY_RANGE - 1)) ? BLD_IDLE : BLD_SETUP;
      end
      BLD_IDLE: begin
        state_nxt = BLD_IDLE;
      end
      default: begin
        state_nxt = BLD_IDLE;
      end
    endcase
    if (start) begin
      state_nxt  = BLD_SETUP;
      idx_nxt    = '0;
      nz_quo_nxt = '0;
      nz_rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BLD_SETUP;
      idx_r    <= '0;
      nz_quo_r <= '0;
      nz_rem_r <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      nz_quo_r <= nz_quo_nxt;
      nz_rem_r <= nz_rem_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gqd_pipe.sv -----
// pixel pipeline: position counters, noise table, level table, output register
`default_nettype none
module gqd_pipe
  import gqd_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire gqd_cfg_t cfg,
  input  wire gqd_wr_t wr,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire gqd_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output gqd_out_t     out_data
);

  localparam int CW   = $clog2(MAX_DIMENSION);
  localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam logic [CMPW-1:0] MAXD = CMPW'(MAX_DIMENSION);

  logic [PIX_W-1:0]  lvl_mem [GRAY_RANGE];
  logic [PIX_W:0]    nz_mem  [NOISE_DEPTH];

  logic [CW-1:0]     col_r, col_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [CMPW-1:0]   w_raw, h_raw, eff_w, eff_h, col_p1, row_p1;
  logic              row_end, plane_end;
  logic              accept, pos;

  logic [NUM_W-1:0]  rsum, rfix;
  logic [PIX_W-1:0]  t_f, t_c;
  logic [NZ_ADDR_W-1:0] nz_addr;

  logic              s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              s1_pos_r, s1_dith_r, s1_end_r;
  logic [PIX_W:0]    nz_rd_r;
  logic              s1_adv;

  logic [LVL_W-1:0]  mag;
  logic [PIX_W+1:0]  up_sum;
  logic [PIX_W-1:0]  v_up, v_dn, lidx;

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_end_r;

  // effective dimensions and position
  always_comb begin
    w_raw     = CMPW'(cfg.image_width);
    h_raw     = CMPW'(cfg.image_height);
    eff_w     = (w_raw == '0) ? CMPW'(1) : ((w_raw > MAXD) ? MAXD : w_raw);
    eff_h     = (h_raw == '0) ? CMPW'(1) : ((h_raw > MAXD) ? MAXD : h_raw);
    col_p1    = CMPW'(col_r) + 1'b1;
    row_p1    = CMPW'(row_r) + 1'b1;
    row_end   = col_p1 >= eff_w;
    plane_end = row_end && (row_p1 >= eff_h);
    col_nxt   = row_end ? '0 : CW'(col_p1);
    row_nxt   = row_r;
    if (row_end) begin
      row_nxt = plane_end ? '0 : CW'(row_p1);
    end
    pos = ~(col_r[0] ^ row_r[0]);
  end

  // noise index: t = (frac * 128) / 65535, floor and ceiling
  always_comb begin
    rsum    = NUM_W'({in_data.noise_fraction[8:0], 7'b0}) +
              NUM_W'(in_data.noise_fraction[15:9]);
    t_f     = PIX_W'(in_data.noise_fraction[15:9]);
    rfix    = rsum;
    if (rsum >= NOISE_DIV) begin
      t_f  = t_f + 1'b1;
      rfix = rsum - NOISE_DIV;
    end
    t_c     = t_f + PIX_W'(rfix != '0);
    nz_addr = pos ? t_c : t_f;
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !wr.busy && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready;

  // dither and clip
  always_comb begin
    mag    = LVL_W'(nz_rd_r[PIX_W:1]) + LVL_W'(s1_pos_r & nz_rd_r[0]);
    up_sum = (PIX_W + 2)'(s1_pix_r) + (PIX_W + 2)'(mag);
    v_up   = (up_sum > (PIX_W + 2)'(GRAY_RANGE - 1)) ? 8'hFF : up_sum[PIX_W-1:0];
    v_dn   = (mag > LVL_W'(s1_pix_r)) ? '0 : PIX_W'(LVL_W'(s1_pix_r) - mag);
    lidx   = !s1_dith_r ? s1_pix_r : (s1_pos_r ? v_up : v_dn);
  end

  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (wr.lvl_we) begin
      lvl_mem[wr.addr] <= wr.lvl_data;
    end
    if (s1_adv) begin
      out_pix_r <= lvl_mem[lidx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.nz_we) begin
      nz_mem[wr.addr] <= {wr.nz_quo, wr.nz_frac};
    end
    if (accept) begin
      nz_rd_r <= nz_mem[nz_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      s1_pix_r  <= in_data.pixel_in;
      s1_pos_r  <= pos;
      s1_dith_r <= cfg.dither_enable;
      s1_end_r  <= plane_end;
    end
    if (s1_adv) begin
      out_end_r <= s1_end_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.pixel_out = out_pix_r;
  assign out_data.plane_end = out_end_r;

endmodule
`default_nettype wire

// ----- hdl/gqd_checker.sv -----
// port-level checker for the gray quantizer with dither, and its bind
`default_nettype none
`include "assert_macros.svh"
module gqd_checker
  import gqd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire gqd_out_t          out_data,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [ADDR_W-1:0] paddr
);

  logic lvl_wr;

  assign lvl_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_LEVELS);

  // tables are rebuilt right after reset, so no transaction is taken
  `GQD_ASSERT_NOW(a_ready_after_reset, $past(!rst_n), !in_ready)

  // a levels write starts a rebuild that blocks the input
  `GQD_ASSERT_NEXT(a_levels_blocks_input, lvl_wr, !in_ready)

  // a stalled result holds
  `GQD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind gray_quantizer_with_dither gqd_checker u_gqd_checker (.*);
`default_nettype wire

// ----- verif/gray_quantizer_with_dither_tb.sv -----
// self-checking testbench of the gray quantizer with dither: scoreboard class and stimulus
`timescale 1ns / 1ps

import gqd_pkg::*;

class quant_scoreboard;
  logic [LVL_W-1:0] levels_reg;
  logic             dither_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [PIX_W-1:0] level_lut [GRAY_RANGE];
  int unsigned      col_pos;
  int unsigned      row_pos;
  gqd_out_t         pending_pixels [$];
  int unsigned      failures;

  function new();
    levels_reg = LEVELS_RST;
    dither_reg = 1'b0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    col_pos    = 0;
    row_pos    = 0;
    failures   = 0;
    rebuild_lut();
  endfunction

  function void rebuild_lut();
    int unsigned n;
    int unsigned q;
    int unsigned v;
    n = (levels_reg == 0) ? 1 : levels_reg;
    for (int i = 0; i < GRAY_RANGE; i++) begin
      q = (i * n) >> 8;
      v = (256 * q + 128) / n;
      if (v > 255) v = 255;
      level_lut[i] = PIX_W'(v);
    end
  endfunction

  function int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function void set_register(gqd_reg_t idx, logic [DATA_W-1:0] word);
    case (idx)
      REG_LEVELS: begin
        levels_reg = word[LVL_W-1:0];
        rebuild_lut();
      end
      REG_DITHER: dither_reg = word[0];
      REG_WIDTH:  width_reg  = word[DIM_W-1:0];
      REG_HEIGHT: height_reg = word[DIM_W-1:0];
      default: ;
    endcase
  endfunction

  // quantized pixel and plane flag for one accepted input transaction
  function void note_pixel(gqd_in_t item);
    int unsigned n;
    int unsigned num;
    int unsigned den;
    int unsigned w;
    int unsigned h;
    int          v;
    gqd_out_t    exp_item;
    n = (levels_reg == 0) ? 1 : levels_reg;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    v = int'(item.pixel_in);
    if (dither_reg) begin
      num = 32'(item.noise_fraction) * 128;
      den = 65535 * n;
      if (((row_pos + col_pos) & 1) == 0) v = v + int'((num + den - 1) / den);
      else v = v - int'(num / den);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end
    exp_item.plane_end = 1'b0;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        exp_item.plane_end = 1'b1;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
    exp_item.pixel_out = level_lut[v];
    pending_pixels.push_back(exp_item);
  endfunction

  function void check_pixel(gqd_out_t got);
    gqd_out_t exp_item;
    if (pending_pixels.size() == 0) begin
      $error("unexpected result: pixel_out %0d plane_end %0d", got.pixel_out, got.plane_end);
      failures++;
      return;
    end
    exp_item = pending_pixels.pop_front();
    if (got.pixel_out !== exp_item.pixel_out) begin
      $error("pixel_out: expected %0d, got %0d", exp_item.pixel_out, got.pixel_out);
      failures++;
    end
    if (got.plane_end !== exp_item.plane_end) begin
      $error("plane_end: expected %0d, got %0d", exp_item.plane_end, got.plane_end);
      failures++;
    end
  endfunction
endclass

module gray_quantizer_with_dither_tb;
  import gqd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned HOLD_OFF    = 300;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 86;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  gqd_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  gqd_out_t          out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned cycles       = 0;

  quant_scoreboard sb = new();

  gray_quantizer_with_dither dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_data);
      if (out_valid && out_ready) sb.check_pixel(out_data);
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // receiver with random stalls and one long hold-off on request
  initial begin : receiver
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end else if (out_calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        gap = pick_gap();
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  function automatic gqd_in_t pixel_item(int unsigned p, int unsigned nf);
    gqd_in_t item;
    item.pixel_in       = PIX_W'(p);
    item.noise_fraction = NOISE_W'(nf);
    return item;
  endfunction

  function automatic gqd_in_t random_item();
    int unsigned p;
    int unsigned nf;
    p  = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) * 255) : $urandom_range(0, 255);
    nf = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) * 65535)
                                     : $urandom_range(0, 65535);
    return pixel_item(p, nf);
  endfunction

  // random junk above the register width, which the block drops
  function automatic logic [DATA_W-1:0] pad_upper(int unsigned value, int unsigned bits);
    if ($urandom_range(0, 3) == 0) return ($urandom() << bits) | value;
    return value;
  endfunction

  task automatic idle_input(int unsigned gap);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  task automatic send_pixel(gqd_in_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (!in_calm && $urandom_range(0, 2) == 0) idle_input(pick_gap());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(gqd_reg_t idx, logic [DATA_W-1:0] word);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, word);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // levels goes last: its write starts the table rebuild
  task automatic configure(logic [DATA_W-1:0] lv, logic [DATA_W-1:0] dith,
                           logic [DATA_W-1:0] w, logic [DATA_W-1:0] h);
    drain();
    apb_write(REG_DITHER, dith);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_LEVELS, lv);
  endtask

  function automatic int unsigned pick_levels();
    int unsigned extremes [6] = '{0, 1, 2, 255, 256, 511};
    case ($urandom_range(0, 3))
      0:       return extremes[$urandom_range(0, 5)];
      1:       return $urandom_range(0, 511);
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  function automatic int unsigned pick_dim(int unsigned small_max);
    int unsigned extremes [5] = '{0, 4096, 4097, 8191, 1};
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom_range(small_max + 1, 40);
      3:       return extremes[$urandom_range(0, 4)];
      4:       return $urandom_range(0, 8191);
      default: return $urandom_range(1, small_max);
    endcase
  endfunction

  task automatic random_phase(int unsigned n_items, bit pressure);
    int unsigned lv;
    int unsigned w;
    int unsigned h;
    bit          dith;
    lv   = pick_levels();
    w    = pick_dim(10);
    h    = pick_dim(5);
    dith = ($urandom_range(0, 3) != 0);
    configure(pad_upper(lv, LVL_W), pad_upper(dith, 1), pad_upper(w, DIM_W),
              pad_upper(h, DIM_W));
    for (int k = 0; k < n_items; k++) begin
      if (pressure && k == 5) hold_off_req = 1'b1;
      send_pixel(random_item());
    end
  endtask

  initial begin : stimulus
    @(posedge rst_n);

    // reset settings
    send_pixel(pixel_item(0, 0));
    send_pixel(pixel_item(255, 65535));
    send_pixel(pixel_item(127, 12345));
    send_pixel(pixel_item(128, 0));
    send_pixel(pixel_item(16, 65535));

    // zero levels and zero dimensions: one level, every pixel ends a plane
    configure(32'd0, 32'd1, 32'd0, 32'd0);
    send_pixel(pixel_item(0, 65535));
    send_pixel(pixel_item(255, 65535));
    send_pixel(pixel_item(128, 0));

    // 256 levels, junk in the upper register bits, tiny plane
    configure(32'hABCD_E100, 32'hFFFF_FFFF, 32'h1234_6003, 32'hFFFF_E002);
    send_pixel(pixel_item(0, 65535));
    send_pixel(pixel_item(255, 65535));
    send_pixel(pixel_item(1, 1));
    send_pixel(pixel_item(254, 65535));
    send_pixel(pixel_item(100, 32768));
    send_pixel(pixel_item(200, 0));

    // levels above 256, dimensions past the maximum
    configure(32'd511, 32'd1, 32'd8191, 32'd8191);
    send_pixel(pixel_item(255, 65535));
    send_pixel(pixel_item(0, 65535));
    send_pixel(pixel_item(0, 0));
    send_pixel(pixel_item(64, 40000));

    // two levels with full noise around the band edge
    configure(32'd2, 32'd1, 32'd4096, 32'd4096);
    send_pixel(pixel_item(127, 65535));
    send_pixel(pixel_item(128, 65535));
    send_pixel(pixel_item(0, 65535));
    send_pixel(pixel_item(255, 65535));

    for (int ph = 0; ph < PHASES; ph++) begin
      in_calm  = (ph % 4 == 3) || (ph == 6);
      out_calm = (ph % 4 == 3);
      random_phase(PHASE_ITEMS, ph == 6);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
